/* rtl/nldbg_pkg.sv */
// Package with types and constants for the dual-bank labelled matrix-vector unit.
`default_nettype none
package nldbg_pkg;
  localparam logic [1:0] OP_LOAD_HIGH = 2'd0;
  localparam logic [1:0] OP_LOAD_LOW  = 2'd1;
  localparam logic [1:0] OP_SAMPLE    = 2'd2;
  localparam int LABEL_OFFSET = 10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TEST,
    ST_MAC,
    ST_EMIT
  } state_t;
endpackage
`default_nettype wire

/* rtl/noisy_label_dual_bank_gemv_unit.sv */
// Top level of the dual-bank labelled matrix-vector unit.
`default_nettype none
// Weight loads and sample elements are accepted while the unit is idle. The
// element marked last starts a spread test, then one shared 16x16
// multiply-accumulate unit computes each row from a registered weight read, and
// each row's dot product waits in the output register until taken. The input is
// not ready from the last element until the final row is taken.
module noisy_label_dual_bank_gemv_unit #(
  parameter int SAMPLE_LENGTH = 16,
  parameter int OUTPUT_ROWS   = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_wr_en,
  input  wire logic [31:0] cfg_wr_data,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // opcode[1:0], row_index[7:2], col_index[13:8], value[29:14], class_label[35:30], pad
  input  wire logic [39:0] in_tdata,
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // out_value[39:0], out_row[45:40], pseudo_label[53:46], pad
  output logic [55:0]      out_tdata,
  output logic             out_tlast
);
  localparam int CW = $clog2(SAMPLE_LENGTH);
  localparam int RW = (OUTPUT_ROWS > 1) ? $clog2(OUTPUT_ROWS) : 1;
  localparam int AW = RW + CW;
  localparam int NW = $clog2(SAMPLE_LENGTH + 1);

  logic [1:0]  op;
  logic [5:0]  in_row, in_col, in_label;
  logic signed [15:0] in_val;
  assign op       = in_tdata[1:0];
  assign in_row   = in_tdata[7:2];
  assign in_col   = in_tdata[13:8];
  assign in_val   = in_tdata[29:14];
  assign in_label = in_tdata[35:30];

  logic [15:0] high_mem [2**AW];
  logic [15:0] low_mem  [2**AW];
  logic signed [15:0] samp_r [SAMPLE_LENGTH];

  nldbg_pkg::state_t state_r, state_nxt;
  logic [31:0] margin_r;
  logic [23:0] abs_sum_r;
  logic [39:0] sq_sum_r;
  logic signed [15:0] best_val_r;
  logic [5:0]  best_pos_r;
  logic [NW-1:0] count_r;
  logic [5:0]  label_r;
  logic signed [7:0] pseudo_r;
  logic        bank_low_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col_r;
  logic        rd_vld_r;
  logic        rd_last_r;
  logic signed [15:0] w_r;
  logic signed [39:0] acc_r;
  logic [2:0]  tstep_r;
  logic [63:0] lhs_r, rhs_r;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic        accept, out_fire, do_test;
  logic [15:0] mag;

  assign accept   = in_tvalid && in_tready;
  assign out_fire = out_tvalid && out_tready;
  assign mag      = in_val[15] ? 16'(-in_val) : in_val;

  always_ff @(posedge clk) begin
    if (accept && op == nldbg_pkg::OP_LOAD_HIGH && 32'(in_row) < OUTPUT_ROWS &&
        32'(in_col) < SAMPLE_LENGTH)
      high_mem[{RW'(in_row), CW'(in_col)}] <= in_val;
    if (accept && op == nldbg_pkg::OP_LOAD_LOW && 32'(in_row) < OUTPUT_ROWS &&
        32'(in_col) < SAMPLE_LENGTH)
      low_mem[{RW'(in_row), CW'(in_col)}] <= in_val;
    w_r <= bank_low_r ? low_mem[{row_r, col_r}] : high_mem[{row_r, col_r}];
  end

  // shared 32x32 unsigned multiplier for the spread test
  always_comb begin
    mul_a = 32'(abs_sum_r);
    mul_b = 32'(abs_sum_r);
    case (tstep_r)
      3'd1: begin mul_a = margin_r; mul_b = 32'(SAMPLE_LENGTH * SAMPLE_LENGTH); end
      default: ;
    endcase
  end
  assign mul_p = 64'(mul_a) * 64'(mul_b);

  always_comb begin
    state_nxt = state_r;
    in_tready = (state_r == nldbg_pkg::ST_IDLE);
    do_test   = 1'b0;
    case (state_r)
      nldbg_pkg::ST_IDLE:
        if (accept && op == nldbg_pkg::OP_SAMPLE && in_tlast) state_nxt = nldbg_pkg::ST_TEST;
      nldbg_pkg::ST_TEST: begin
        do_test = 1'b1;
        if (tstep_r == 3'd3) state_nxt = nldbg_pkg::ST_MAC;
      end
      nldbg_pkg::ST_MAC:
        if (rd_last_r) state_nxt = nldbg_pkg::ST_EMIT;
      nldbg_pkg::ST_EMIT:
        if (out_fire) state_nxt = (out_tlast) ? nldbg_pkg::ST_IDLE : nldbg_pkg::ST_MAC;
      default: state_nxt = nldbg_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= nldbg_pkg::ST_IDLE;
      margin_r <= '0; abs_sum_r <= '0; sq_sum_r <= '0; best_val_r <= '0;
      best_pos_r <= '0; count_r <= '0; label_r <= '0; tstep_r <= '0;
      rd_vld_r <= 1'b0; rd_last_r <= 1'b0; out_tvalid <= 1'b0;
      row_r <= '0; col_r <= '0; bank_low_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) margin_r <= cfg_wr_data;
      if (accept && op == nldbg_pkg::OP_SAMPLE) begin
        label_r <= in_label;
        if (32'(count_r) < SAMPLE_LENGTH) begin
          samp_r[CW'(count_r)] <= in_val;
          abs_sum_r <= abs_sum_r + 24'(mag);
          sq_sum_r  <= sq_sum_r + 40'(32'(mag) * 32'(mag));
          if (count_r == '0 || in_val > best_val_r) begin
            best_val_r <= in_val;
            best_pos_r <= 6'(count_r);
          end
          count_r <= count_r + 1'b1;
        end
      end
      if (do_test) begin
        if (tstep_r != 3'd3) tstep_r <= tstep_r + 3'd1;
        case (tstep_r)
          3'd0: begin
            rhs_r <= mul_p;
            lhs_r <= 64'(sq_sum_r) * 64'(SAMPLE_LENGTH);
            for (int k = 0; k < SAMPLE_LENGTH; k++)
              if (k >= 32'(count_r)) samp_r[k] <= '0;
            if (32'(count_r) < SAMPLE_LENGTH && (count_r == '0 || best_val_r < 0)) begin
              best_val_r <= '0;
              best_pos_r <= 6'(count_r);
            end
          end
          3'd1: rhs_r <= rhs_r + mul_p;
          3'd2: begin
            if (lhs_r > rhs_r)
              pseudo_r <= (label_r == best_pos_r) ? 8'(label_r) : -8'sd1;
            else
              pseudo_r <= 8'(label_r) + 8'(nldbg_pkg::LABEL_OFFSET);
          end
          default: begin
            bank_low_r <= !(pseudo_r < $signed(8'(nldbg_pkg::LABEL_OFFSET)));
            row_r <= '0; col_r <= '0; tstep_r <= '0; acc_r <= '0;
            abs_sum_r <= '0; sq_sum_r <= '0; best_val_r <= '0; best_pos_r <= '0;
            count_r <= '0;
          end
        endcase
      end
      if (state_r == nldbg_pkg::ST_MAC) begin
        rd_vld_r  <= !rd_last_r;
        rd_last_r <= 32'(col_r) == SAMPLE_LENGTH - 1 && !rd_last_r;
        if (!rd_last_r && 32'(col_r) != SAMPLE_LENGTH - 1) col_r <= col_r + 1'b1;
        if (rd_vld_r) acc_r <= acc_r + 40'(32'(w_r) * 32'(samp_r[col_r - CW'(rd_last_r ? 0 : 1)]));
        if (rd_last_r) out_tvalid <= 1'b1;
      end
      if (out_fire) begin
        out_tvalid <= 1'b0;
        acc_r <= '0;
        col_r <= '0;
        row_r <= row_r + 1'b1;
      end
    end
  end

  assign out_tdata = {2'b0, pseudo_r, 6'(row_r), acc_r};
  assign out_tlast = 32'(row_r) == OUTPUT_ROWS - 1;

  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("ready while result pending");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata)) else $error("result changed");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == nldbg_pkg::ST_MAC |-> count_r == '0) else $error("sums not cleared");
endmodule
`default_nettype wire
